/* src/eebe_pkg.sv */
// ----------------------------------------------------------------------------
// eebe_pkg - edge element basis evaluation package
// Codes, basis tables and axis-pair lookups shared by the evaluation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package eebe_pkg;

	// command codes
	localparam logic [1:0] CMD_VALUE = 2'd0;
	localparam logic [1:0] CMD_D1    = 2'd1;
	localparam logic [1:0] CMD_D2    = 2'd2;
	localparam logic [1:0] CMD_BAD   = 2'd3;

	// element kinds
	localparam logic [1:0] ELEM_HEX = 2'd0;
	localparam logic [1:0] ELEM_TET = 2'd1;

	localparam logic [3:0] HEX_EDGES = 4'd12;
	localparam logic [3:0] TET_EDGES = 4'd6;

	localparam logic [2:0] D1_DIRS = 3'd3;
	localparam logic [2:0] D2_DIRS = 3'd6;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_ORDER = 3'd1;
	localparam logic [2:0] ST_BAD_ELEM  = 3'd2;
	localparam logic [2:0] ST_BAD_INDEX = 3'd3;
	localparam logic [2:0] ST_BAD_DIR   = 3'd4;

	// axes
	localparam logic [1:0] AX_XI   = 2'd0;
	localparam logic [1:0] AX_ETA  = 2'd1;
	localparam logic [1:0] AX_ZETA = 2'd2;

	// unit coefficient codes
	localparam logic [1:0] U_Z = 2'b00;
	localparam logic [1:0] U_P = 2'b01;
	localparam logic [1:0] U_M = 2'b11;

	// hex function: k * (1 + sa*ua) * (1 + sb*ub) / 8 in component comp
	typedef struct packed {
		logic [1:0] comp;
		logic       k_neg;
		logic [1:0] axis_a;
		logic       sa_neg;
		logic [1:0] axis_b;
		logic       sb_neg;
	} hex_ent_t;

	typedef struct packed {
		logic [1:0] cx;
		logic [1:0] cy;
		logic [1:0] cz;
	} unit_vec_t;

	typedef struct packed {
		logic [1:0] lo;
		logic [1:0] hi;
	} axis_pair_t;

	function automatic hex_ent_t hex_entry(input logic [3:0] idx);
		hex_ent_t e;
		case (idx)
			4'd0:    e = '{AX_XI,   1'b1, AX_ETA, 1'b1, AX_ZETA, 1'b1};
			4'd1:    e = '{AX_ETA,  1'b1, AX_XI,  1'b0, AX_ZETA, 1'b1};
			4'd2:    e = '{AX_XI,   1'b0, AX_ETA, 1'b0, AX_ZETA, 1'b1};
			4'd3:    e = '{AX_ETA,  1'b1, AX_XI,  1'b1, AX_ZETA, 1'b1};
			4'd4:    e = '{AX_ZETA, 1'b1, AX_XI,  1'b1, AX_ETA,  1'b1};
			4'd5:    e = '{AX_ZETA, 1'b1, AX_XI,  1'b0, AX_ETA,  1'b1};
			4'd6:    e = '{AX_ZETA, 1'b1, AX_XI,  1'b0, AX_ETA,  1'b0};
			4'd7:    e = '{AX_ZETA, 1'b1, AX_XI,  1'b1, AX_ETA,  1'b0};
			4'd8:    e = '{AX_XI,   1'b1, AX_ETA, 1'b1, AX_ZETA, 1'b0};
			4'd9:    e = '{AX_ETA,  1'b1, AX_XI,  1'b0, AX_ZETA, 1'b0};
			4'd10:   e = '{AX_XI,   1'b0, AX_ETA, 1'b0, AX_ZETA, 1'b0};
			4'd11:   e = '{AX_ETA,  1'b1, AX_XI,  1'b1, AX_ZETA, 1'b0};
			default: e = '0;
		endcase
		return e;
	endfunction

	// tetrahedron first derivatives: constant unit vectors per direction and index
	function automatic unit_vec_t tet_d1(input logic [1:0] dir, input logic [2:0] idx);
		unit_vec_t v;
		v = '{U_Z, U_Z, U_Z};
		case (dir)
			2'd0: begin
				case (idx)
					3'd0:    v = '{U_Z, U_M, U_M};
					3'd1:    v = '{U_Z, U_M, U_Z};
					3'd2:    v = '{U_Z, U_P, U_Z};
					3'd3:    v = '{U_Z, U_Z, U_P};
					3'd4:    v = '{U_Z, U_Z, U_M};
					default: v = '{U_Z, U_Z, U_Z};
				endcase
			end
			2'd1: begin
				case (idx)
					3'd0:    v = '{U_P, U_Z, U_Z};
					3'd1:    v = '{U_P, U_Z, U_Z};
					3'd2:    v = '{U_M, U_Z, U_M};
					3'd3:    v = '{U_Z, U_Z, U_P};
					3'd5:    v = '{U_Z, U_Z, U_M};
					default: v = '{U_Z, U_Z, U_Z};
				endcase
			end
			2'd2: begin
				case (idx)
					3'd0:    v = '{U_P, U_Z, U_Z};
					3'd2:    v = '{U_Z, U_P, U_Z};
					3'd3:    v = '{U_M, U_M, U_Z};
					3'd4:    v = '{U_P, U_Z, U_Z};
					3'd5:    v = '{U_Z, U_P, U_Z};
					default: v = '{U_Z, U_Z, U_Z};
				endcase
			end
			default: v = '{U_Z, U_Z, U_Z};
		endcase
		return v;
	endfunction

	// second derivative directions xx, xy, yy, xz, yz, zz
	function automatic axis_pair_t d2_pair(input logic [2:0] dir);
		axis_pair_t p;
		case (dir)
			3'd0:    p = '{AX_XI,   AX_XI};
			3'd1:    p = '{AX_XI,   AX_ETA};
			3'd2:    p = '{AX_ETA,  AX_ETA};
			3'd3:    p = '{AX_XI,   AX_ZETA};
			3'd4:    p = '{AX_ETA,  AX_ZETA};
			3'd5:    p = '{AX_ZETA, AX_ZETA};
			default: p = '{AX_XI,   AX_XI};
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

/* src/edge_element_basis_eval_unit.sv */
// ----------------------------------------------------------------------------
// edge_element_basis_eval_unit - lowest-order edge basis evaluator
// Value, first or second partial derivative of one hex or tet edge basis
// function at a reference point, signed fixed point, saturated, with status.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload
//  --------  -----------------  ------------------------------------------------
//  request   start / busy       cmd elem_kind base_order refine_level use_refine
//                               edge_index direction orientation xi eta zeta
//  result    done (one cycle)   comp_x comp_y comp_z status
//
//  A request is taken at every clock edge with start high; busy stays low, so
//  one request per cycle is sustained. Its result passes the input register,
//  then the single product of the two hex factors and the rounding into the
//  result register, and shows on done.
//  The receiver cannot stall; results leave in request order, one per request.
//  arst_n clears both valid flags; the payload registers are not reset.
//
`default_nettype none

module edge_element_basis_eval_unit import eebe_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    cmd,
	input  wire logic [1:0]                    elem_kind,
	input  wire logic [3:0]                    base_order,
	input  wire logic [3:0]                    refine_level,
	input  wire logic                          use_refine,
	input  wire logic [3:0]                    edge_index,
	input  wire logic [2:0]                    direction,
	input  wire logic                          orientation,
	input  wire logic signed [COORD_WIDTH-1:0] xi,
	input  wire logic signed [COORD_WIDTH-1:0] eta,
	input  wire logic signed [COORD_WIDTH-1:0] zeta,
	output logic                               done,
	output logic signed [COORD_WIDTH-1:0]      comp_x,
	output logic signed [COORD_WIDTH-1:0]      comp_y,
	output logic signed [COORD_WIDTH-1:0]      comp_z,
	output logic [2:0]                         status
);

	localparam int W    = COORD_WIDTH;
	localparam int FRAC = W - 2;
	localparam int XW   = W + 2;     // headroom for 1 +/- u and its negation

	localparam logic signed [XW-1:0] ONE_X   = (XW)'(1) <<< FRAC;
	localparam logic signed [XW-1:0] EIGHTH_X = (XW)'(1) <<< (FRAC - 3);
	localparam logic [2*W:0]         HALF_P   = (2*W+1)'(1) << (FRAC + 2);
	localparam logic [W:0]           HALF_3   = (W+1)'(4);

	// input register
	logic                valid_s1;
	logic [1:0]          cmd_s1;
	logic [1:0]          kind_s1;
	logic [3:0]          order_s1;
	logic [3:0]          refine_s1;
	logic                use_ref_s1;
	logic [3:0]          idx_s1;
	logic [2:0]          dir_s1;
	logic                orient_s1;
	logic signed [W-1:0] xi_s1, eta_s1, zeta_s1;

	// result register
	logic                valid_s2;
	logic signed [W-1:0] cx_s2, cy_s2, cz_s2;
	logic [2:0]          status_s2;

	// nothing in the datapath ever holds a request off
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_s1     <= cmd;
			kind_s1    <= elem_kind;
			order_s1   <= base_order;
			refine_s1  <= refine_level;
			use_ref_s1 <= use_refine;
			idx_s1     <= edge_index;
			dir_s1     <= direction;
			orient_s1  <= orientation;
			xi_s1      <= xi;
			eta_s1     <= eta;
			zeta_s1    <= zeta;
		end
	end

	// ---------------- checks, in precedence order ----------------
	logic [4:0] total;
	logic [2:0] st;
	logic       bad_dir;

	assign total   = {1'b0, order_s1} + (use_ref_s1 ? {1'b0, refine_s1} : 5'd0);
	assign bad_dir = (cmd_s1 == CMD_BAD) ||
	                 (cmd_s1 == CMD_D1 && dir_s1 >= D1_DIRS) ||
	                 (cmd_s1 == CMD_D2 && dir_s1 >= D2_DIRS);

	always_comb begin
		if (total != 5'd1) begin
			st = ST_BAD_ORDER;
		end else if (kind_s1 != ELEM_HEX && kind_s1 != ELEM_TET) begin
			st = ST_BAD_ELEM;
		end else if (idx_s1 >= (kind_s1 == ELEM_HEX ? HEX_EDGES : TET_EDGES)) begin
			st = ST_BAD_INDEX;
		end else if (bad_dir) begin
			st = ST_BAD_DIR;
		end else begin
			st = ST_OK;
		end
	end

	// widen coordinates
	logic signed [XW-1:0] ux, ue, uz;
	assign ux = XW'(xi_s1);
	assign ue = XW'(eta_s1);
	assign uz = XW'(zeta_s1);

	function automatic logic signed [XW-1:0] pick_axis(input logic [1:0] ax,
			input logic signed [XW-1:0] a0, input logic signed [XW-1:0] a1,
			input logic signed [XW-1:0] a2);
		logic signed [XW-1:0] r;
		case (ax)
			AX_XI:   r = a0;
			AX_ETA:  r = a1;
			AX_ZETA: r = a2;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [XW-1:0] unit_val(input logic [1:0] c);
		logic signed [XW-1:0] r;
		case (c)
			U_P:     r = ONE_X;
			U_M:     r = -ONE_X;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [XW-1:0] apply_sign(input logic [W-1:0] mag,
			input logic neg);
		logic signed [XW-1:0] m;
		m = {2'b00, mag};
		return neg ? -m : m;
	endfunction

	// ---------------- hexahedron ----------------
	hex_ent_t             ent;
	logic signed [XW-1:0] ua, ub, fa, fb;
	logic [W-1:0]         mag_a, mag_b;
	logic [2*W:0]         prod_rnd;
	logic [W:0]           rnd_a, rnd_b;
	logic signed [XW-1:0] hex_r;
	axis_pair_t           pr;
	logic                 pair_hit;

	assign ent   = hex_entry(idx_s1);
	assign ua    = pick_axis(ent.axis_a, ux, ue, uz);
	assign ub    = pick_axis(ent.axis_b, ux, ue, uz);
	assign fa    = ent.sa_neg ? ONE_X - ua : ONE_X + ua;
	assign fb    = ent.sb_neg ? ONE_X - ub : ONE_X + ub;
	assign mag_a = fa[XW-1] ? W'(-fa) : W'(fa);
	assign mag_b = fb[XW-1] ? W'(-fb) : W'(fb);

	// round to nearest, ties away from zero, on the magnitude
	assign prod_rnd = {1'b0, (2*W)'(mag_a) * (2*W)'(mag_b)} + HALF_P;
	assign rnd_a    = {1'b0, mag_a} + HALF_3;
	assign rnd_b    = {1'b0, mag_b} + HALF_3;

	assign pr       = d2_pair(dir_s1);
	assign pair_hit = (pr.lo != pr.hi) &&
	                  ((pr.lo == ent.axis_a && pr.hi == ent.axis_b) ||
	                   (pr.lo == ent.axis_b && pr.hi == ent.axis_a));

	always_comb begin
		hex_r = '0;
		case (cmd_s1)
			CMD_VALUE: begin
				hex_r = apply_sign(prod_rnd[FRAC+3 +: W],
				                   fa[XW-1] ^ fb[XW-1] ^ ent.k_neg);
			end
			CMD_D1: begin
				if (dir_s1 == {1'b0, ent.axis_a}) begin
					hex_r = apply_sign(W'(rnd_b[W:3]), fb[XW-1] ^ ent.k_neg ^ ent.sa_neg);
				end else if (dir_s1 == {1'b0, ent.axis_b}) begin
					hex_r = apply_sign(W'(rnd_a[W:3]), fa[XW-1] ^ ent.k_neg ^ ent.sb_neg);
				end
			end
			CMD_D2: begin
				if (pair_hit) begin
					hex_r = (ent.k_neg ^ ent.sa_neg ^ ent.sb_neg) ? -EIGHTH_X : EIGHTH_X;
				end
			end
			default: hex_r = '0;
		endcase
	end

	// ---------------- tetrahedron ----------------
	logic signed [XW-1:0] tx, ty, tz;
	unit_vec_t            tv;

	assign tv = tet_d1(dir_s1[1:0], idx_s1[2:0]);

	always_comb begin
		tx = '0;
		ty = '0;
		tz = '0;
		case (cmd_s1)
			CMD_VALUE: begin
				case (idx_s1[2:0])
					3'd0: begin
						tx = -ONE_X + ue + uz;
						ty = -ux;
						tz = -ux;
					end
					3'd1: begin
						tx = ue;
						ty = -ux;
					end
					3'd2: begin
						tx = -ue;
						ty = -ONE_X + ux + uz;
						tz = -ue;
					end
					3'd3: begin
						tx = -uz;
						ty = -uz;
						tz = -ONE_X + ux + ue;
					end
					3'd4: begin
						tx = uz;
						tz = -ux;
					end
					default: begin
						ty = uz;
						tz = -ue;
					end
				endcase
			end
			CMD_D1: begin
				tx = unit_val(tv.cx);
				ty = unit_val(tv.cy);
				tz = unit_val(tv.cz);
			end
			default: begin
				tx = '0;
			end
		endcase
	end

	// ---------------- merge, orient, saturate ----------------
	logic signed [XW-1:0] vx, vy, vz;

	always_comb begin
		vx = '0;
		vy = '0;
		vz = '0;
		if (st == ST_OK) begin
			if (kind_s1 == ELEM_HEX) begin
				case (ent.comp)
					AX_XI:   vx = hex_r;
					AX_ETA:  vy = hex_r;
					default: vz = hex_r;
				endcase
			end else begin
				vx = tx;
				vy = ty;
				vz = tz;
			end
		end
	end

	function automatic logic signed [W-1:0] sat(input logic signed [XW-1:0] v,
			input logic keep);
		logic signed [XW-1:0] s;
		s = keep ? v : -v;
		if (s[XW-1:W-1] == '0 || s[XW-1:W-1] == '1) begin
			return s[W-1:0];
		end
		return s[XW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			cx_s2     <= sat(vx, orient_s1);
			cy_s2     <= sat(vy, orient_s1);
			cz_s2     <= sat(vz, orient_s1);
			status_s2 <= st;
		end
	end

	assign done   = valid_s2;
	assign comp_x = cx_s2;
	assign comp_y = cy_s2;
	assign comp_z = cz_s2;
	assign status = status_s2;

	// ---------------- assertions ----------------
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##2 done)
		else $error("request did not give a result two cycles later");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result strobe without a request in flight");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (comp_x == '0 && comp_y == '0 && comp_z == '0))
		else $error("error result carries non-zero components");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= ST_BAD_DIR))
		else $error("status code out of range");

endmodule

`default_nettype wire
